// ===== hdl/tpcu_pkg.sv =====
// Package for the packed pattern cell unpacker: result word layout and fixed codes.
// No dependencies; used by tracker_pattern_cell_unpacker, tpcu_checker and tb.
`timescale 1ns / 1ps
`default_nettype none

package tpcu_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NoteW  = 9;
  localparam int unsigned ChanW  = 5;
  localparam int unsigned RowW   = 8;
  localparam int unsigned CfgW   = 6;
  localparam int unsigned MaskW  = 5;
  localparam int unsigned OutPad = 2;

  // Mask and note codes
  localparam logic [MaskW-1:0] FULL_MASK   = 5'h1E;
  localparam logic [ByteW-1:0] KEY_OFF_RAW = 8'h61;
  localparam logic [NoteW-1:0] KEY_OFF_OUT = 9'd121;
  localparam logic [NoteW-1:0] NOTE_OFFSET = 9'd12;

  // Channel count limits and reset value
  localparam logic [CfgW-1:0] CHAN_MIN   = 6'd1;
  localparam logic [CfgW-1:0] CHAN_MAX   = 6'd32;
  localparam logic [CfgW-1:0] CHAN_RESET = 6'd8;

  // Result word, note in the lowest bits
  typedef struct packed {
    logic [OutPad-1:0] pad;
    logic [RowW-1:0]   row_index;
    logic [ChanW-1:0]  channel_index;
    logic [ByteW-1:0]  effect_argument;
    logic [ByteW-1:0]  effect_code;
    logic [ByteW-1:0]  volume_byte;
    logic [ByteW-1:0]  instrument_number;
    logic [NoteW-1:0]  note_value;
  } out_t;

  localparam int unsigned OutW = $bits(out_t);

  // Bytes collected so far for the cell being assembled
  typedef struct packed {
    logic [ByteW-1:0] note;
    logic [ByteW-1:0] instrument;
    logic [ByteW-1:0] volume;
    logic [ByteW-1:0] effect;
  } cell_t;

  // Raw note byte to output note
  function automatic logic [NoteW-1:0] map_note(input logic [ByteW-1:0] raw);
    logic [NoteW-1:0] res;
    if (raw == KEY_OFF_RAW) begin
      res = KEY_OFF_OUT;
    end else if (raw == '0) begin
      res = '0;
    end else begin
      res = {1'b0, raw} + NOTE_OFFSET;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tracker_pattern_cell_unpacker.sv =====
// Packed pattern cell unpacker: byte stream in, one result word per complete cell.
// Depends on tpcu_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Dir | Handshake                    | Payload
// ----------+-----+------------------------------+----------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata: data_byte; tuser: new_pattern
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata: cell fields, note lowest
// cfg       | in  | cfg_valid_i/cfg_ready_o      | cfg_data_i: chans_per_row
//
// One byte per cycle while no result is held; a cell result appears in the cycle after its last byte.
// Assembly state and the result word are registered; the mask decode, note map
// and counter update sit between them.
// Reset clears the cell state and counters and sets the channel count to 8.
// A result not yet taken holds m_axis; s_axis is then ready only in a cycle in
// which the result is taken. cfg is always ready.

module tracker_pattern_cell_unpacker
  import tpcu_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CfgW-1:0]   cfg_data_i,     // chans_per_row
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [ByteW-1:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]        s_axis_tuser,   // [0] new_pattern
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [OutW-1:0]        m_axis_tdata    // [8:0] note_value, [16:9] instrument_number,
                                                 // [24:17] volume_byte, [32:25] effect_code,
                                                 // [40:33] effect_argument, [45:41] channel_index,
                                                 // [53:46] row_index, [55:54] zero
);

  logic [CfgW-1:0]  chan_cnt_q;
  logic [MaskW-1:0] mask_q, mask_d;
  cell_t            cell_q, cell_d;
  logic [ChanW-1:0] chan_q, chan_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             in_fire;
  logic [MaskW-1:0] mask_s;
  cell_t            cell_s;
  logic [ChanW-1:0] chan_s;
  logic [RowW-1:0]  row_s;
  logic [MaskW-1:0] sel;
  logic [ByteW-1:0] arg;
  logic             emit;
  logic [CfgW-1:0]  limit;
  logic [CfgW-1:0]  chan_inc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Clamp the configured channel count to 1..32
  always_comb begin
    if (chan_cnt_q < CHAN_MIN) begin
      limit = CHAN_MIN;
    end else if (chan_cnt_q > CHAN_MAX) begin
      limit = CHAN_MAX;
    end else begin
      limit = chan_cnt_q;
    end
  end

  // Cell assembly for the incoming word
  always_comb begin
    // start of pattern drops the partial cell and counters
    if (s_axis_tuser[0]) begin
      mask_s = '0;
      cell_s = '0;
      chan_s = '0;
      row_s  = '0;
    end else begin
      mask_s = mask_q;
      cell_s = cell_q;
      chan_s = chan_q;
      row_s  = row_q;
    end

    cell_d = cell_s;
    mask_d = mask_s;
    arg    = '0;
    sel    = mask_s & (~mask_s + 5'd1);

    if (mask_s == '0) begin
      // first byte of a cell: mask or implied full cell
      if (s_axis_tdata[7]) begin
        mask_d = s_axis_tdata[MaskW-1:0];
      end else begin
        mask_d      = FULL_MASK;
        cell_d.note = {1'b0, s_axis_tdata[6:0]};
      end
    end else begin
      // field byte for the lowest pending mask bit
      if (sel[0]) cell_d.note       = s_axis_tdata;
      if (sel[1]) cell_d.instrument = s_axis_tdata;
      if (sel[2]) cell_d.volume     = s_axis_tdata;
      if (sel[3]) cell_d.effect     = s_axis_tdata;
      if (sel[4]) arg               = s_axis_tdata;
      mask_d = mask_s & ~sel;
    end

    emit = (mask_d == '0);

    out_d                   = '0;
    out_d.note_value        = map_note(cell_d.note);
    out_d.instrument_number = cell_d.instrument;
    out_d.volume_byte       = cell_d.volume;
    out_d.effect_code       = cell_d.effect;
    out_d.effect_argument   = arg;
    out_d.channel_index     = chan_s;
    out_d.row_index         = row_s;

    // counters advance per completed cell
    chan_inc = {1'b0, chan_s} + 6'd1;
    chan_d   = chan_s;
    row_d    = row_s;
    if (emit) begin
      cell_d = '0;
      if (chan_inc >= limit) begin
        chan_d = '0;
        row_d  = row_s + 8'd1;
      end else begin
        chan_d = chan_inc[ChanW-1:0];
      end
    end

    // result register: load on a completed cell, drop when taken
    if (in_fire) begin
      out_valid_d = emit;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q <= CHAN_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      chan_cnt_q <= cfg_data_i;
    end
  end

  // Assembly state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      cell_q      <= '0;
      chan_q      <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        mask_q <= mask_d;
        cell_q <= cell_d;
        chan_q <= chan_d;
        row_q  <= row_d;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tpcu_checker.sv =====
// Port-level checker for the packed pattern cell unpacker, bound to the top level.
// Depends on tpcu_pkg and tracker_pattern_cell_unpacker.
`timescale 1ns / 1ps
`default_nettype none

module tpcu_checker
  import tpcu_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [ByteW-1:0] s_axis_tdata,
  input wire logic [0:0]       s_axis_tuser,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OutW-1:0]  m_axis_tdata
);

  out_t res;
  assign res = m_axis_tdata;

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Input is taken only when the result slot is free or draining
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted over a stalled result");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready with empty result slot");

  // Notes are zero, key off or raised by the offset
  a_note_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.note_value == '0 || res.note_value > NOTE_OFFSET)
    else $error("note value in the gap below the offset");

  // Empty mask at pattern start gives a cell at channel 0, row 0
  a_new_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && s_axis_tdata[7]
      && s_axis_tdata[MaskW-1:0] == '0
    |=> m_axis_tvalid && res.channel_index == '0 && res.row_index == '0)
    else $error("pattern start cell not at origin");

endmodule

bind tracker_pattern_cell_unpacker tpcu_checker u_tpcu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for tracker_pattern_cell_unpacker: byte stream in, unpacked cells out.
// Needs tpcu_pkg and the unpacker RTL; holds its own cell assembler to predict each word.
`timescale 1ns / 1ps

module tb;
  import tpcu_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 4;     // result word is registered behind its last byte
  localparam int STALL_LIMIT  = 1000;  // cycles with no word moved on any channel
  localparam int REPORT_MAX   = 10;
  localparam int PHASES       = 8;

  // One directed byte; pin marks a row whose cell is typed in by hand
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             np;
    logic             pin;
    logic [NoteW-1:0] note;
    logic [ByteW-1:0] inst;
    logic [ByteW-1:0] vol;
    logic [ByteW-1:0] eff;
    logic [ByteW-1:0] arg;
    logic [ChanW-1:0] chan;
    logic [RowW-1:0]  row;
  } stim_row_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [CfgW-1:0]  cfg_data_i    = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata  = '0;   // [7:0] data_byte
  logic [0:0]       s_axis_tuser  = '0;   // [0] new_pattern
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutW-1:0]  m_axis_tdata;         // note, instrument, volume, effect, argument,
                                          // channel, row, zero pad

  tracker_pattern_cell_unpacker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Directed bytes: extremes, every field, key off, ignored mask bits, dropped partial cell
  stim_row_t directed_rows [25] = '{
    // empty mask straight after reset
    '{8'h80, 1'b0, 1'b1, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    // every field named, all bytes at maximum
    '{8'h9F, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'hFF, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'hFF, 1'b0, 1'b1, 9'd267, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 5'd1, 8'd0},
    // implied note of zero, all fields zero
    '{8'h00, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h00, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h00, 1'b0, 1'b1, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd2, 8'd0},
    // implied key off
    '{8'h61, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h01, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h40, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h0F, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h06, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    // note and instrument, bits 5 and 6 set, 8-bit note after a mask
    '{8'hE3, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h8C, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h11, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    // volume only
    '{8'h84, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h50, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    // partial cell dropped by a new pattern, then an empty mask with bit 5
    '{8'h9F, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'h12, 1'b0, 1'b0, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0},
    '{8'hA0, 1'b1, 1'b1, 9'd0,   8'h00, 8'h00, 8'h00, 8'h00, 5'd0, 8'd0}
  };

  // Assembler state mirrored from the block
  logic [CfgW-1:0]  chan_count_q;
  logic [2:0]       phase_q;
  logic [MaskW-1:0] mask_q;
  logic [ByteW-1:0] note_q, inst_q, vol_q, eff_q;
  logic [ChanW-1:0] chan_q;
  logic [RowW-1:0]  row_q;

  out_t cells_due [$];      // predicted words not yet seen on m_axis
  out_t typed_cells [int];  // hand-typed words, keyed by input byte number

  int  bytes_sent   = 0;
  int  bytes_taken  = 0;
  int  mismatch_cnt = 0;
  int  quiet_cycles = 0;
  int  stall_left   = 0;
  bit  calm_tail    = 1'b0;
  bit  stream_gaps  = 1'b1;
  bit  sink_stalls  = 1'b1;

  task automatic clear_assembly();
    phase_q = '0;
    mask_q  = '0;
    note_q  = '0;
    inst_q  = '0;
    vol_q   = '0;
    eff_q   = '0;
  endtask

  // Next awaited field as 1 + field number, 0 when none left
  function automatic logic [2:0] next_phase(input logic [MaskW-1:0] m);
    for (int i = 0; i < MaskW; i++) begin
      if (m[i]) return 3'(i + 1);
    end
    return '0;
  endfunction

  // Take one byte into the cell being built; done goes high when a cell completes
  task automatic unpack_byte(input logic [ByteW-1:0] b, input logic np,
                             output bit done, output out_t emitted);
    logic [2:0]       field;
    logic [ByteW-1:0] arg;
    int               lim;
    done    = 1'b0;
    emitted = '0;
    arg     = '0;
    if (np) begin
      clear_assembly();
      chan_q = '0;
      row_q  = '0;
    end
    if (phase_q == '0) begin
      if (b[7]) begin
        mask_q = b[MaskW-1:0];
      end else begin
        mask_q = FULL_MASK;
        note_q = {1'b0, b[6:0]};
      end
    end else begin
      field = phase_q - 3'd1;
      case (field)
        3'd0: note_q = b;
        3'd1: inst_q = b;
        3'd2: vol_q  = b;
        3'd3: eff_q  = b;
        default: arg = b;
      endcase
      mask_q[field] = 1'b0;
    end
    phase_q = next_phase(mask_q);
    if (phase_q == '0) begin
      // cell complete: map the note and step the channel and row
      lim = int'(chan_count_q);
      if (lim < int'(CHAN_MIN)) lim = int'(CHAN_MIN);
      if (lim > int'(CHAN_MAX)) lim = int'(CHAN_MAX);
      if (note_q == KEY_OFF_RAW) begin
        emitted.note_value = KEY_OFF_OUT;
      end else if (note_q == '0) begin
        emitted.note_value = '0;
      end else begin
        emitted.note_value = {1'b0, note_q} + NOTE_OFFSET;
      end
      emitted.instrument_number = inst_q;
      emitted.volume_byte       = vol_q;
      emitted.effect_code       = eff_q;
      emitted.effect_argument   = arg;
      emitted.channel_index     = chan_q;
      emitted.row_index         = row_q;
      if (int'(chan_q) + 1 >= lim) begin
        chan_q = '0;
        row_q  = row_q + 8'd1;
      end else begin
        chan_q = chan_q + 5'd1;
      end
      clear_assembly();
      done = 1'b1;
    end
  endtask

  task automatic note_mismatch(input string why, input out_t want, input out_t got);
    if (mismatch_cnt < REPORT_MAX) begin
      $display("%s: want note %0d ins %0d vol %0d eff %0d arg %0d ch %0d row %0d pad %0d",
               why, want.note_value, want.instrument_number, want.volume_byte,
               want.effect_code, want.effect_argument, want.channel_index,
               want.row_index, want.pad);
      $display("%s:  got note %0d ins %0d vol %0d eff %0d arg %0d ch %0d row %0d pad %0d",
               why, got.note_value, got.instrument_number, got.volume_byte,
               got.effect_code, got.effect_argument, got.channel_index,
               got.row_index, got.pad);
    end
    mismatch_cnt++;
  endtask

  // Predict on every accepted byte, check every accepted word, watch for a hang
  always @(posedge clk_i) begin : check_proc
    out_t fresh, want, got;
    bit   done, bad;
    if (!rst_ni) begin
      chan_count_q = CHAN_RESET;
      clear_assembly();
      chan_q       = '0;
      row_q        = '0;
      quiet_cycles = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) chan_count_q = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        unpack_byte(s_axis_tdata, s_axis_tuser[0], done, fresh);
        if (typed_cells.exists(bytes_taken)) begin
          fresh = typed_cells[bytes_taken];
          typed_cells.delete(bytes_taken);
          done = 1'b1;
        end
        if (done) cells_due.push_back(fresh);
        bytes_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = out_t'(m_axis_tdata);
        if (cells_due.size() == 0) begin
          note_mismatch("unexpected word", '0, got);
        end else begin
          want = cells_due.pop_front();
          bad = (got.note_value        !== want.note_value)        ||
                (got.instrument_number !== want.instrument_number) ||
                (got.volume_byte       !== want.volume_byte)       ||
                (got.effect_code       !== want.effect_code)       ||
                (got.effect_argument   !== want.effect_argument)   ||
                (got.channel_index     !== want.channel_index)     ||
                (got.row_index         !== want.row_index)         ||
                (got.pad               !== want.pad);
          if (bad) note_mismatch("field mismatch", want, got);
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: stall bursts, switched on and off, none in the calm tail
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 39) == 0) sink_stalls = !sink_stalls;
      if (stall_left == 0 && sink_stalls && !calm_tail && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      m_axis_tready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Present one byte, with an optional gap first, and wait for it to be taken
  task automatic send_byte(input logic [ByteW-1:0] b, input logic np);
    int gap;
    gap = 0;
    if ($urandom_range(0, 29) == 0) stream_gaps = !stream_gaps;
    if (stream_gaps && !calm_tail && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= np;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // One random cell: mostly well formed, some truncated, some noise
  task automatic send_pattern_cell(input int empty_pct, input bit np_en);
    int               pick, n;
    logic [MaskW-1:0] fields;
    logic             np;
    pick = $urandom_range(0, 99);
    np   = np_en && ($urandom_range(0, 39) == 0);
    if (pick < empty_pct) begin
      send_byte({1'b1, 2'($urandom_range(0, 3)), 5'b0}, np);
    end else if (pick < empty_pct + (100 - empty_pct) * 4 / 10) begin
      send_byte({1'b0, 7'($urandom_range(0, 127))}, np);
      repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 95) begin
      fields = 5'($urandom_range(0, 31));
      send_byte({1'b1, 2'($urandom_range(0, 3)), fields}, np);
      n = $countones(fields);
      if ($urandom_range(0, 14) == 0) n = $urandom_range(0, n);
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_byte(8'($urandom_range(0, 255)), np_en ? 1'($urandom_range(0, 1)) : 1'b0);
    end
  endtask

  // Stop the stream and let every outstanding word drain; a clock edge first lets the
  // last accepted byte be booked
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (cells_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_chans_per_row(input logic [CfgW-1:0] count);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= count;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [CfgW-1:0] phase_count [PHASES];
    int              phase_len   [PHASES];
    int              stop_at;
    out_t            typed;

    // channel count per phase: extremes first, the first phase long enough to wrap the row
    phase_count = '{6'd1, 6'd32, 6'd0, 6'd63, 6'($urandom_range(1, 32)), 6'd5,
                    6'($urandom_range(0, 63)), 6'($urandom_range(1, 32))};
    phase_len   = '{400, 70, 50, 50, 60, 60, 60, 80};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].pin) begin
        typed                   = '0;
        typed.note_value        = directed_rows[i].note;
        typed.instrument_number = directed_rows[i].inst;
        typed.volume_byte       = directed_rows[i].vol;
        typed.effect_code       = directed_rows[i].eff;
        typed.effect_argument   = directed_rows[i].arg;
        typed.channel_index     = directed_rows[i].chan;
        typed.row_index         = directed_rows[i].row;
        typed_cells[bytes_sent] = typed;
      end
      send_byte(directed_rows[i].data, directed_rows[i].np);
    end

    // random phases, count rewritten while idle
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_chans_per_row(phase_count[ph]);
      if (ph == PHASES - 1) calm_tail = 1'b1;
      stop_at = bytes_sent + phase_len[ph];
      while (bytes_sent < stop_at) begin
        if (ph == 0) send_pattern_cell(90, 1'b0);
        else         send_pattern_cell(15, 1'b1);
      end
    end

    settle();
    if (mismatch_cnt == 0 && cells_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tpcu_pkg.sv
hdl/tracker_pattern_cell_unpacker.sv
hdl/tpcu_checker.sv
dv/tb.sv
